// File: hw/rtl/sjf_pkg.sv
package sjf_pkg;

	localparam int TASK_SLOTS = 16;
	localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CNT_W = $clog2(TASK_SLOTS + 1);

	typedef enum logic [2:0] {
		EV_ADD      = 3'd0,
		EV_DISPATCH = 3'd1,
		EV_YIELD    = 3'd2,
		EV_BLOCK    = 3'd3,
		EV_EXIT     = 3'd4,
		EV_WAKE     = 3'd5
	} event_t;

	typedef enum logic [2:0] {
		RES_OK           = 3'd0,
		RES_FULL         = 3'd1,
		RES_NO_READY     = 3'd2,
		RES_NONE_RUNNING = 3'd3,
		RES_WAKE_IGNORED = 3'd4,
		RES_BUSY         = 3'd5
	} result_t;

	typedef enum logic [1:0] {
		TS_READY    = 2'd0,
		TS_RUNNING  = 2'd1,
		TS_BLOCKED  = 2'd2,
		TS_FINISHED = 2'd3
	} task_state_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_PICK,
		S_SEL,
		S_RMW,
		S_RESP
	} fsm_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] burst;
		logic [3:0]  task_id;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] chosen_id;
		logic       first_start;
	} out_item_t;

	typedef struct packed {
		logic        started;
		task_state_t state;
		logic [31:0] burst;
	} slot_entry_t;

	function automatic logic [3:0] to_id(input logic [IDX_W-1:0] slot);
		logic [IDX_W+3:0] ext;
		ext = {4'b0000, slot};
		return ext[3:0];
	endfunction

endpackage

// File: hw/rtl/sjf_task_scheduler.sv
// From input transfer to result transfer: START then RESP for add, unknown events and events
// refused at the first check (dispatch while running or with an empty table, yield, block
// or exit with nothing running, wake of an unused slot).
// Yield, block, exit and wake of a used slot: START, RMW, RESP (one read-modify-write of the table).
// Dispatch with used slots: START, SCAN of every used slot, PICK, SEL, RESP; one comparator, one slot a cycle.
// One event at a time: the next input transfer is taken on return to idle.
// Reset (arst_n low, asynchronous): table empty, no task running, no result pending.
module sjf_task_scheduler (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sjf_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sjf_pkg::out_item_t   out_data
);

	sjf_pkg::fsm_t state_q, state_d;

	logic [2:0]                  mode_q;
	logic [31:0]                 burst_q;
	logic [3:0]                  tid_q;
	logic [sjf_pkg::IDX_W-1:0]   idx_q;
	logic                        cmp_vld_q;
	logic [sjf_pkg::IDX_W-1:0]   cmp_idx_q;
	logic                        found_q;
	logic [sjf_pkg::IDX_W-1:0]   best_q;
	logic [31:0]                 best_burst_q;
	logic                        best_started_q;
	logic [sjf_pkg::CNT_W-1:0]   used_q;
	logic                        run_vld_q;
	logic [sjf_pkg::IDX_W-1:0]   run_slot_q;
	sjf_pkg::out_item_t          res_q;
	logic                        out_valid_q;
	sjf_pkg::out_item_t          out_q;
	sjf_pkg::slot_entry_t        rd_q;

	sjf_pkg::slot_entry_t        slot_mem [sjf_pkg::TASK_SLOTS];

	logic [sjf_pkg::IDX_W-1:0]   rd_addr;
	logic                        wr_en;
	logic [sjf_pkg::IDX_W-1:0]   wr_addr;
	sjf_pkg::slot_entry_t        wr_data;
	logic                        res_ld;
	sjf_pkg::out_item_t          res_d;
	logic                        used_inc;
	logic                        run_set;
	logic                        run_clr;
	logic                        scan_clr;
	logic                        scan_last;
	logic                        wake_ok;
	logic                        in_xfer;
	logic                        out_load;
	logic [sjf_pkg::IDX_W+3:0]   tid_ext;
	sjf_pkg::task_state_t        leave_state;

	assign in_ready  = (state_q == sjf_pkg::S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_load  = (state_q == sjf_pkg::S_RESP) && (!out_valid_q || out_ready);

	assign scan_last = ((sjf_pkg::CNT_W'(idx_q) + sjf_pkg::CNT_W'(1)) == used_q);
	assign wake_ok   = ({{sjf_pkg::CNT_W{1'b0}}, tid_q} < {4'b0000, used_q});
	assign tid_ext   = {{sjf_pkg::IDX_W{1'b0}}, tid_q};

	always_comb begin
		case (mode_q)
			sjf_pkg::EV_YIELD: begin
				leave_state = sjf_pkg::TS_READY;
			end
			sjf_pkg::EV_BLOCK: begin
				leave_state = sjf_pkg::TS_BLOCKED;
			end
			default: begin
				leave_state = sjf_pkg::TS_FINISHED;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sjf_pkg::S_IDLE: begin
				if (in_xfer)
					state_d = sjf_pkg::S_START;
			end
			sjf_pkg::S_START: begin
				state_d = sjf_pkg::S_RESP;
				case (mode_q)
					sjf_pkg::EV_DISPATCH: begin
						if (!run_vld_q && used_q != '0)
							state_d = sjf_pkg::S_SCAN;
					end
					sjf_pkg::EV_YIELD, sjf_pkg::EV_BLOCK, sjf_pkg::EV_EXIT: begin
						if (run_vld_q)
							state_d = sjf_pkg::S_RMW;
					end
					sjf_pkg::EV_WAKE: begin
						if (wake_ok)
							state_d = sjf_pkg::S_RMW;
					end
					default: begin
						state_d = sjf_pkg::S_RESP;
					end
				endcase
			end
			sjf_pkg::S_SCAN: begin
				if (scan_last)
					state_d = sjf_pkg::S_PICK;
			end
			sjf_pkg::S_PICK: begin
				state_d = sjf_pkg::S_SEL;
			end
			sjf_pkg::S_SEL: begin
				state_d = sjf_pkg::S_RESP;
			end
			sjf_pkg::S_RMW: begin
				state_d = sjf_pkg::S_RESP;
			end
			sjf_pkg::S_RESP: begin
				if (out_load)
					state_d = sjf_pkg::S_IDLE;
			end
			default: begin
				state_d = sjf_pkg::S_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		rd_addr   = idx_q;
		wr_en     = 1'b0;
		wr_addr   = used_q[sjf_pkg::IDX_W-1:0];
		wr_data   = rd_q;
		res_ld    = 1'b0;
		res_d     = '0;
		used_inc  = 1'b0;
		run_set   = 1'b0;
		run_clr   = 1'b0;
		scan_clr  = 1'b0;
		case (state_q)
			sjf_pkg::S_START: begin
				scan_clr = 1'b1;
				case (mode_q)
					sjf_pkg::EV_ADD: begin
						res_ld = 1'b1;
						if (used_q >= sjf_pkg::CNT_W'(sjf_pkg::TASK_SLOTS)) begin
							res_d.status = sjf_pkg::RES_FULL;
						end else begin
							wr_en           = 1'b1;
							wr_data.started = 1'b0;
							wr_data.state   = sjf_pkg::TS_READY;
							wr_data.burst   = burst_q;
							res_d.chosen_id = sjf_pkg::to_id(used_q[sjf_pkg::IDX_W-1:0]);
							used_inc        = 1'b1;
						end
					end
					sjf_pkg::EV_DISPATCH: begin
						if (run_vld_q) begin
							res_ld       = 1'b1;
							res_d.status = sjf_pkg::RES_BUSY;
						end else if (used_q == '0) begin
							res_ld       = 1'b1;
							res_d.status = sjf_pkg::RES_NO_READY;
						end
					end
					sjf_pkg::EV_YIELD, sjf_pkg::EV_BLOCK, sjf_pkg::EV_EXIT: begin
						rd_addr = run_slot_q;
						if (!run_vld_q) begin
							res_ld       = 1'b1;
							res_d.status = sjf_pkg::RES_NONE_RUNNING;
						end
					end
					sjf_pkg::EV_WAKE: begin
						rd_addr = tid_ext[sjf_pkg::IDX_W-1:0];
						if (!wake_ok) begin
							res_ld       = 1'b1;
							res_d.status = sjf_pkg::RES_WAKE_IGNORED;
						end
					end
					default: begin
						res_ld = 1'b1;
					end
				endcase
			end
			sjf_pkg::S_SEL: begin
				res_ld = 1'b1;
				if (!found_q) begin
					res_d.status = sjf_pkg::RES_NO_READY;
				end else begin
					wr_en             = 1'b1;
					wr_addr           = best_q;
					wr_data.started   = 1'b1;
					wr_data.state     = sjf_pkg::TS_RUNNING;
					wr_data.burst     = best_burst_q;
					res_d.chosen_id   = sjf_pkg::to_id(best_q);
					res_d.first_start = !best_started_q;
					run_set           = 1'b1;
				end
			end
			sjf_pkg::S_RMW: begin
				res_ld = 1'b1;
				if (mode_q == sjf_pkg::EV_WAKE) begin
					wr_addr = tid_ext[sjf_pkg::IDX_W-1:0];
					if (rd_q.state == sjf_pkg::TS_BLOCKED) begin
						wr_en         = 1'b1;
						wr_data.state = sjf_pkg::TS_READY;
					end else begin
						res_d.status = sjf_pkg::RES_WAKE_IGNORED;
					end
				end else begin
					wr_en         = 1'b1;
					wr_addr       = run_slot_q;
					wr_data.state = leave_state;
					run_clr       = 1'b1;
				end
			end
			default: begin
				rd_addr = idx_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			slot_mem[wr_addr] <= wr_data;
		rd_q <= slot_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_q  <= in_data.mode;
			burst_q <= in_data.burst;
			tid_q   <= in_data.task_id;
		end
		if (res_ld)
			res_q <= res_d;
		if (out_load)
			out_q <= res_q;
		cmp_idx_q <= idx_q;
		if (cmp_vld_q && rd_q.state == sjf_pkg::TS_READY &&
				(!found_q || rd_q.burst < best_burst_q)) begin
			best_q         <= cmp_idx_q;
			best_burst_q   <= rd_q.burst;
			best_started_q <= rd_q.started;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sjf_pkg::S_IDLE;
			idx_q       <= '0;
			cmp_vld_q   <= 1'b0;
			found_q     <= 1'b0;
			used_q      <= '0;
			run_vld_q   <= 1'b0;
			run_slot_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cmp_vld_q <= (state_q == sjf_pkg::S_SCAN);
			if (scan_clr) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (state_q == sjf_pkg::S_SCAN) begin
				idx_q <= idx_q + sjf_pkg::IDX_W'(1);
			end
			if (cmp_vld_q && rd_q.state == sjf_pkg::TS_READY)
				found_q <= 1'b1;
			if (used_inc)
				used_q <= used_q + sjf_pkg::CNT_W'(1);
			if (run_set) begin
				run_vld_q  <= 1'b1;
				run_slot_q <= best_q;
			end else if (run_clr) begin
				run_vld_q  <= 1'b0;
				run_slot_q <= '0;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= sjf_pkg::CNT_W'(sjf_pkg::TASK_SLOTS))
		else $error("slot count beyond table size");

	a_run_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(run_vld_q) |-> $past(state_q == sjf_pkg::S_SEL) &&
			res_q.status == sjf_pkg::RES_OK)
		else $error("task started running outside of dispatch");

	a_run_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(run_vld_q) |-> $past(state_q == sjf_pkg::S_RMW) &&
			$past(mode_q != sjf_pkg::EV_WAKE))
		else $error("running task left without yield, block or exit");

	a_best_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sjf_pkg::S_SEL && found_q) |->
			sjf_pkg::CNT_W'(best_q) < used_q)
		else $error("dispatch chose an unused slot");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> !$past(state_q == sjf_pkg::S_RESP) || $past(out_load))
		else $error("new event taken with result still unsent");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import sjf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors = 0;
	int cycles = 0;

	// scheduler shadow state
	task_state_t slot_st[TASK_SLOTS];
	logic [31:0] slot_len[TASK_SLOTS];
	bit slot_begun[TASK_SLOTS];
	int n_used = 0;
	bit cpu_busy = 1'b0;
	int cpu_slot = 0;

	out_item_t expected_results[$];

	sjf_task_scheduler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	function automatic in_item_t mk_event(logic [2:0] mode, logic [31:0] burst,
			logic [3:0] tid);
		in_item_t it;
		it.mode = mode;
		it.burst = burst;
		it.task_id = tid;
		return it;
	endfunction

	function automatic out_item_t sched_apply(in_item_t it);
		out_item_t r;
		bit found;
		int best;
		r = '0;
		r.status = RES_OK;
		case (it.mode)
			EV_ADD: begin
				if (n_used >= TASK_SLOTS) begin
					r.status = RES_FULL;
				end else begin
					slot_st[n_used] = TS_READY;
					slot_len[n_used] = it.burst;
					slot_begun[n_used] = 1'b0;
					r.chosen_id = 4'(n_used);
					n_used++;
				end
			end
			EV_DISPATCH: begin
				if (cpu_busy) begin
					r.status = RES_BUSY;
				end else begin
					found = 1'b0;
					best = 0;
					for (int i = 0; i < n_used; i++) begin
						if (slot_st[i] == TS_READY && (!found || slot_len[i] < slot_len[best])) begin
							found = 1'b1;
							best = i;
						end
					end
					if (!found) begin
						r.status = RES_NO_READY;
					end else begin
						r.first_start = !slot_begun[best];
						slot_begun[best] = 1'b1;
						slot_st[best] = TS_RUNNING;
						cpu_busy = 1'b1;
						cpu_slot = best;
						r.chosen_id = 4'(best);
					end
				end
			end
			EV_YIELD, EV_BLOCK, EV_EXIT: begin
				if (!cpu_busy) begin
					r.status = RES_NONE_RUNNING;
				end else begin
					slot_st[cpu_slot] = (it.mode == EV_YIELD) ? TS_READY :
						(it.mode == EV_BLOCK) ? TS_BLOCKED : TS_FINISHED;
					cpu_busy = 1'b0;
					cpu_slot = 0;
				end
			end
			EV_WAKE: begin
				if (int'(it.task_id) < n_used && slot_st[it.task_id] == TS_BLOCKED) begin
					slot_st[it.task_id] = TS_READY;
				end else begin
					r.status = RES_WAKE_IGNORED;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic in_item_t pick_event();
		in_item_t it;
		int roll;
		int alive;
		int blocked[$];
		it = mk_event(EV_ADD, $urandom, 4'($urandom_range(15)));
		alive = 0;
		for (int i = 0; i < n_used; i++) begin
			if (slot_st[i] != TS_FINISHED)
				alive++;
			if (slot_st[i] == TS_BLOCKED)
				blocked.push_back(i);
		end
		roll = $urandom_range(99);
		if (roll < 15) begin
			it.mode = EV_ADD;
			case ($urandom_range(7))
				0, 1: it.burst = $urandom_range(7);
				2: it.burst = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
				default: ;
			endcase
		end else if (roll < 40) begin
			it.mode = EV_DISPATCH;
		end else if (roll < 58) begin
			it.mode = EV_YIELD;
		end else if (roll < 72) begin
			it.mode = EV_BLOCK;
		end else if (roll < 80) begin
			// keep enough live tasks around for the rest of the run
			it.mode = (alive > 4) ? EV_EXIT : EV_YIELD;
		end else if (roll < 96) begin
			it.mode = EV_WAKE;
			if (blocked.size() != 0 && $urandom_range(3) != 0)
				it.task_id = 4'(blocked[$urandom_range(blocked.size() - 1)]);
		end else begin
			it.mode = 3'($urandom_range(7, 6));
		end
		return it;
	endfunction

	task automatic send_event(in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(sched_apply(it));
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic note_error(string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				note_error($sformatf("unexpected result status %0d id %0d first %0d",
					out_data.status, out_data.chosen_id, out_data.first_start));
			end else begin
				want = expected_results.pop_front();
				if (out_data.status !== want.status || out_data.chosen_id !== want.chosen_id ||
						out_data.first_start !== want.first_start)
					note_error($sformatf(
						"mismatch: expected status %0d id %0d first %0d, got %0d %0d %0d",
						want.status, want.chosen_id, want.first_start,
						out_data.status, out_data.chosen_id, out_data.first_start));
			end
		end
	end

	task automatic test_empty_table();
		send_event(mk_event(EV_DISPATCH, $urandom, 4'hF));
		send_event(mk_event(EV_YIELD, $urandom, 4'h0));
		send_event(mk_event(EV_BLOCK, $urandom, 4'h5));
		send_event(mk_event(EV_EXIT, $urandom, 4'hA));
		send_event(mk_event(EV_WAKE, $urandom, 4'h0));
		send_event(mk_event(3'd6, 32'hFFFF_FFFF, 4'hF));
		send_event(mk_event(3'd7, 32'h0, 4'h0));
	endtask

	task automatic test_scheduling();
		send_event(mk_event(EV_ADD, 32'hFFFF_FFFF, 4'h0));
		send_event(mk_event(EV_DISPATCH, 32'h0, 4'h0));
		send_event(mk_event(EV_DISPATCH, 32'h0, 4'h0));
		send_event(mk_event(EV_YIELD, 32'h0, 4'h0));
		send_event(mk_event(EV_ADD, 32'h0, 4'hF));
		send_event(mk_event(EV_ADD, 32'd7, 4'h0));
		send_event(mk_event(EV_ADD, 32'd7, 4'h0));
		send_event(mk_event(EV_DISPATCH, 32'h0, 4'h0));
		send_event(mk_event(EV_EXIT, 32'h0, 4'h0));
		send_event(mk_event(EV_DISPATCH, 32'h0, 4'h0));
		send_event(mk_event(EV_BLOCK, 32'h0, 4'h0));
		send_event(mk_event(EV_WAKE, 32'h0, 4'd2));
		send_event(mk_event(EV_WAKE, 32'h0, 4'd2));
		send_event(mk_event(EV_WAKE, 32'hFFFF_FFFF, 4'd15));
		send_event(mk_event(EV_DISPATCH, 32'h0, 4'h0));
		send_event(mk_event(EV_YIELD, 32'h0, 4'h0));
		send_event(mk_event(EV_DISPATCH, 32'h0, 4'h0));
		send_event(mk_event(EV_EXIT, 32'h0, 4'h0));
	endtask

	task automatic test_random(int snd_pct, int rcv_pct, int count);
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		repeat (count)
			send_event(pick_event());
	endtask

	task automatic test_table_full();
		while (n_used < TASK_SLOTS)
			send_event(mk_event(EV_ADD, $urandom, 4'($urandom_range(15))));
		send_event(mk_event(EV_ADD, $urandom, 4'($urandom_range(15))));
	endtask

	initial begin
		send_idle_pct = 28;
		recv_idle_pct = 50;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_scheduling();
		test_random(28, 50, 265);
		hold_until_drained();
		test_random(50, 28, 265);
		hold_until_drained();
		test_random(0, 0, 265);
		test_table_full();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
